// ===== rtl/keyword_substitution_cipher_assert.svh =====
// Assertion macros shared by the keyword substitution cipher RTL.
// Each macro expands to one labelled concurrent assertion that reports by $error.
// No dependencies; include guard below.
`ifndef KEYWORD_SUBSTITUTION_CIPHER_ASSERT_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_ASSERT_SVH

// Assertion on an explicit clock and active-low reset.
`define KSC_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion on the block's usual clk_i and rst_ni.
`define KSC_ASSERT(name, prop, msg) `KSC_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/ksc_pkg.sv =====
// Package for the keyword substitution cipher: command codes, controller states
// and the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package ksc_pkg;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned LetterW = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR   = 3'd0,
    CMD_KEY     = 3'd1,
    CMD_FINISH  = 3'd2,
    CMD_ENCRYPT = 3'd3,
    CMD_DECRYPT = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FILL,
    ST_INVERT,
    ST_INV_LAST
  } state_e;

  typedef struct packed {
    logic clear_en;
    logic key_en;
    logic lookup_en;
    logic lookup_dec;
    logic fill_en;
    logic inv_rd_en;
    logic walk_en;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/ksc_datapath.sv =====
// Datapath of the keyword substitution cipher: cipher and plain table memories,
// used mask, fill count, walk counter and result register. Depends on ksc_pkg.
`default_nettype none
`include "keyword_substitution_cipher_assert.svh"

module ksc_datapath #(
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ksc_pkg::ctrl_cmd_t            cmd_i,
  input  wire logic [ksc_pkg::LetterW-1:0]   letter_i,
  output      ksc_pkg::dp_status_t           status_o,
  output      logic [ksc_pkg::LetterW-1:0]   letter_out_o
);

  localparam int unsigned LW = ksc_pkg::LetterW;
  localparam int unsigned IW = $clog2(ALPHABET_SIZE);
  localparam int unsigned FW = $clog2(ALPHABET_SIZE + 1);
  localparam logic [IW-1:0] LastIdx = IW'(ALPHABET_SIZE - 1);
  localparam logic [FW-1:0] FullCnt = FW'(ALPHABET_SIZE);
  localparam logic [LW:0]   SizeExt = (LW + 1)'(ALPHABET_SIZE);

  logic [IW-1:0] cipher_mem [ALPHABET_SIZE];
  logic [IW-1:0] plain_mem  [ALPHABET_SIZE];

  logic [ALPHABET_SIZE-1:0] cipher_vld_q, cipher_vld_d;
  logic [ALPHABET_SIZE-1:0] plain_vld_q, plain_vld_d;
  logic [ALPHABET_SIZE-1:0] used_q, used_d;
  logic [FW-1:0]            fill_q, fill_d;
  logic [IW-1:0]            walk_q, walk_d;
  logic                     inv_pend_q;

  logic [IW-1:0] rd_cdata_q, rd_pdata_q, rd_idx_q;
  logic          rd_cvld_q, rd_pvld_q, rd_inr_q, rd_dec_q;
  logic [LW-1:0] rd_letter_q;
  logic [LW-1:0] out_q, out_d;

  logic          in_range;
  logic [IW-1:0] lk_addr, rd_addr;
  logic          not_full, key_wr, fill_wr, cwr_en;
  logic [IW-1:0] cwr_addr, cwr_data;
  logic [IW-1:0] rd_eff_c, rd_eff_p, lk_val;
  logic          walk_last;

  assign in_range  = {1'b0, letter_i} < SizeExt;
  assign lk_addr   = in_range ? letter_i[IW-1:0] : '0;
  assign rd_addr   = cmd_i.lookup_en ? lk_addr : walk_q;
  assign walk_last = (walk_q == LastIdx);
  assign not_full  = (fill_q < FullCnt);

  assign key_wr   = cmd_i.key_en && in_range && !used_q[lk_addr] && not_full;
  assign fill_wr  = cmd_i.fill_en && !used_q[walk_q] && not_full;
  assign cwr_en   = key_wr || fill_wr;
  assign cwr_addr = fill_q[IW-1:0];
  assign cwr_data = key_wr ? lk_addr : walk_q;

  assign rd_eff_c = rd_cvld_q ? rd_cdata_q : rd_idx_q;
  assign rd_eff_p = rd_pvld_q ? rd_pdata_q : rd_idx_q;
  assign lk_val   = rd_dec_q ? rd_eff_p : rd_eff_c;
  assign out_d    = rd_inr_q ? LW'(lk_val) : rd_letter_q;

  always_comb begin
    cipher_vld_d = cipher_vld_q;
    plain_vld_d  = plain_vld_q;
    used_d       = used_q;
    fill_d       = fill_q;
    walk_d       = walk_q;
    if (cmd_i.clear_en) begin
      cipher_vld_d = '0;
      plain_vld_d  = '0;
      used_d       = '0;
      fill_d       = '0;
    end else begin
      if (cwr_en) begin
        cipher_vld_d[cwr_addr] = 1'b1;
        fill_d                 = fill_q + 1'b1;
      end
      if (key_wr) begin
        used_d[lk_addr] = 1'b1;
      end
      if (cmd_i.fill_en) begin
        used_d[walk_q] = 1'b1;
      end
      if (inv_pend_q) begin
        plain_vld_d[rd_eff_c] = 1'b1;
      end
    end
    if (cmd_i.walk_en) begin
      walk_d = walk_last ? '0 : walk_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cipher_vld_q <= '0;
      plain_vld_q  <= '0;
      used_q       <= '0;
      fill_q       <= '0;
      walk_q       <= '0;
      inv_pend_q   <= 1'b0;
    end else begin
      cipher_vld_q <= cipher_vld_d;
      plain_vld_q  <= plain_vld_d;
      used_q       <= used_d;
      fill_q       <= fill_d;
      walk_q       <= walk_d;
      inv_pend_q   <= cmd_i.inv_rd_en;
    end
  end

  // Table memories: one write port and one registered read port each.
  always_ff @(posedge clk_i) begin
    if (cwr_en) begin
      cipher_mem[cwr_addr] <= cwr_data;
    end
    if (inv_pend_q) begin
      plain_mem[rd_eff_c] <= rd_idx_q;
    end
    if (cmd_i.lookup_en || cmd_i.inv_rd_en) begin
      rd_cdata_q  <= cipher_mem[rd_addr];
      rd_pdata_q  <= plain_mem[lk_addr];
      rd_cvld_q   <= cipher_vld_q[rd_addr];
      rd_pvld_q   <= plain_vld_q[lk_addr];
      rd_idx_q    <= rd_addr;
      rd_inr_q    <= in_range;
      rd_dec_q    <= cmd_i.lookup_dec;
      rd_letter_q <= letter_i;
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign status_o.walk_last = walk_last;
  assign letter_out_o       = out_q;

  `KSC_ASSERT(a_fill_completes, cmd_i.fill_en && walk_last |=> fill_q == FullCnt && (&used_q),
              "Alphabet not full after the fill walk.")
  `KSC_ASSERT(a_fill_bounded, cwr_en |-> fill_q < FullCnt,
              "Cipher table written beyond the alphabet.")

endmodule

`default_nettype wire

// ===== rtl/ksc_ctrl.sv =====
// Controller of the keyword substitution cipher: sequences lookups and the finish
// walk, and owns both stream handshakes. Depends on ksc_pkg and the assertion header.
`default_nettype none
`include "keyword_substitution_cipher_assert.svh"

module ksc_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic [ksc_pkg::CmdW-1:0]     command_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  input  wire ksc_pkg::dp_status_t          status_i,
  output      ksc_pkg::ctrl_cmd_t           cmd_o
);

  ksc_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free, accept, is_lookup, is_finish;
  ksc_pkg::cmd_e   cmd;

  assign cmd       = ksc_pkg::cmd_e'(command_i);
  assign out_free  = !out_valid_q || out_ready_i;
  assign is_lookup = (cmd == ksc_pkg::CMD_ENCRYPT) || (cmd == ksc_pkg::CMD_DECRYPT);
  assign is_finish = (cmd == ksc_pkg::CMD_FINISH);
  assign accept    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ksc_pkg::ST_IDLE, ksc_pkg::ST_LOOKUP: begin
        if (accept) begin
          if (is_lookup) begin
            state_d = ksc_pkg::ST_LOOKUP;
          end else if (is_finish) begin
            state_d = ksc_pkg::ST_FILL;
          end else begin
            state_d = ksc_pkg::ST_IDLE;
          end
        end else if (state_q == ksc_pkg::ST_LOOKUP && out_free) begin
          state_d = ksc_pkg::ST_IDLE;
        end
      end
      ksc_pkg::ST_FILL: begin
        if (status_i.walk_last) begin
          state_d = ksc_pkg::ST_INVERT;
        end
      end
      ksc_pkg::ST_INVERT: begin
        if (status_i.walk_last) begin
          state_d = ksc_pkg::ST_INV_LAST;
        end
      end
      ksc_pkg::ST_INV_LAST: begin
        state_d = ksc_pkg::ST_IDLE;
      end
      default: begin
        state_d = ksc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    unique case (state_q)
      ksc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ksc_pkg::ST_LOOKUP: begin
        in_ready_o = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ksc_pkg::ST_LOOKUP: begin
        cmd_o.out_load = out_free;
      end
      ksc_pkg::ST_FILL: begin
        cmd_o.fill_en = 1'b1;
        cmd_o.walk_en = 1'b1;
      end
      ksc_pkg::ST_INVERT: begin
        cmd_o.inv_rd_en = 1'b1;
        cmd_o.walk_en   = 1'b1;
      end
      default: begin
        cmd_o.out_load = 1'b0;
      end
    endcase
    cmd_o.clear_en   = accept && (cmd == ksc_pkg::CMD_CLEAR);
    cmd_o.key_en     = accept && (cmd == ksc_pkg::CMD_KEY);
    cmd_o.lookup_en  = accept && is_lookup;
    cmd_o.lookup_dec = (cmd == ksc_pkg::CMD_DECRYPT);
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ksc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `KSC_ASSERT(a_finish_busy, accept && is_finish |=> !in_ready_o,
              "Input accepted straight after a finish command.")
  `KSC_ASSERT(a_invert_after_fill,
              state_q == ksc_pkg::ST_INVERT |->
              $past(state_q) == ksc_pkg::ST_FILL || $past(state_q) == ksc_pkg::ST_INVERT,
              "Inverse build entered without a fill walk.")
  `KSC_ASSERT(a_result_from_lookup, $rose(out_valid_q) |-> $past(state_q) == ksc_pkg::ST_LOOKUP,
              "Result raised without a lookup.")

endmodule

`default_nettype wire

// ===== rtl/keyword_substitution_cipher.sv =====
// Encrypt and decrypt results pass through the table read port registers and then the
// result register; a lookup is taken every cycle while the result register drains, the
// table read port setting it. Finish holds off the input while one walk fills the
// cipher table and a second builds the inverse.
// Reset is asynchronous and active low; per-entry valid bits make both tables read
// as the identity at once, so no clearing pass follows reset.
// Top level: joins ksc_ctrl and ksc_datapath; depends on ksc_pkg.
`default_nettype none

module keyword_substitution_cipher #(
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output      logic       s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [4:0] letter, [7:5] zero
  input  wire logic [2:0] s_axis_tuser,   // [2:0] command
  output      logic       m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output      logic [7:0] m_axis_tdata    // [4:0] letter_out, [7:5] zero
);

  ksc_pkg::ctrl_cmd_t              cmd;
  ksc_pkg::dp_status_t             status;
  logic [ksc_pkg::LetterW-1:0]     letter_out;

  ksc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .command_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ksc_datapath #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .letter_i     (s_axis_tdata[ksc_pkg::LetterW-1:0]),
    .status_o     (status),
    .letter_out_o (letter_out)
  );

  assign m_axis_tdata = 8'(letter_out);

endmodule

`default_nettype wire
